[sv/interval_overlap_removal_count_macros.svh]
// Assertion helpers for the interval overlap removal block.
`ifndef INTERVAL_OVERLAP_REMOVAL_COUNT_MACROS_SVH
`define INTERVAL_OVERLAP_REMOVAL_COUNT_MACROS_SVH

`ifndef SYNTHESIS
// Property holds at every rising clock edge outside reset.
`define IOC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Condition never holds outside reset.
`define IOC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define IOC_ASSERT(lbl, clk, rstn, prop)
`define IOC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[sv/ioc_pkg.sv]
package ioc_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  // One stored interval.
  typedef struct packed {
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
  } span_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic [COUNT_W-1:0] removal_count;
    logic               overflowed;
  } res_t;

endpackage

[sv/ioc_store.sv]
module ioc_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  ioc_pkg::span_t wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output ioc_pkg::span_t rdata_o
);

  ioc_pkg::span_t mem_q [DEPTH];
  ioc_pkg::span_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/ioc_seq.sv]
module ioc_seq #(
  parameter int unsigned MAX_INTERVALS = 64,
  parameter int unsigned AW            = 6,
  parameter int unsigned CW            = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [ioc_pkg::VALUE_W-1:0] interval_start_i,
  input  logic signed [ioc_pkg::VALUE_W-1:0] interval_end_i,
  input  logic                        last_of_set_i,
  output logic                        we_o,
  output logic [AW-1:0]               waddr_o,
  output ioc_pkg::span_t              wdata_o,
  output logic [AW-1:0]               raddr_o,
  input  ioc_pkg::span_t              rdata_i,
  input  logic                        res_free_i,
  output logic                        res_valid_o,
  output ioc_pkg::res_t               res_o,
  output logic [CW-1:0]               count_o
);

  typedef enum logic [3:0] {
    S_LOAD, S_KEY_RD, S_KEY_LAT, S_CMP, S_PLACE,
    S_SCAN_RD0, S_SCAN_FIRST, S_SCAN, S_DONE
  } state_e;

  localparam logic [CW-1:0] MaxCnt = CW'(MAX_INTERVALS);

  state_e                            state_q, state_d;
  logic [CW-1:0]                     cnt_q, cnt_d;
  logic                              ovf_q, ovf_d;
  logic [CW-1:0]                     i_q, i_d;
  logic [CW-1:0]                     j_q, j_d;
  ioc_pkg::span_t                    key_q, key_d;
  logic signed [ioc_pkg::VALUE_W-1:0] edge_q, edge_d;
  logic [ioc_pkg::COUNT_W-1:0]       rem_q, rem_d;
  logic [CW-1:0]                     i_inc;
  logic [CW-1:0]                     i_dec;
  logic [CW-1:0]                     j_dec;
  logic [CW-1:0]                     j_dec2;
  logic [CW-1:0]                     n_next;
  logic                              has_room;

  assign i_inc    = i_q + 1'b1;
  assign i_dec    = i_q - 1'b1;
  assign j_dec    = j_q - 1'b1;
  assign j_dec2   = j_q - CW'(2);
  assign has_room = (cnt_q < MaxCnt);
  assign n_next   = has_room ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    key_d       = key_q;
    edge_d      = edge_q;
    rem_d       = rem_q;
    we_o        = 1'b0;
    waddr_o     = j_q[AW-1:0];
    wdata_o     = key_q;
    raddr_o     = i_q[AW-1:0];
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (has_room) begin
            we_o       = 1'b1;
            waddr_o    = cnt_q[AW-1:0];
            wdata_o.lo = interval_start_i;
            wdata_o.hi = interval_end_i;
            cnt_d      = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_of_set_i) begin
            rem_d = '0;
            i_d   = CW'(1);
            if (n_next >= CW'(2)) begin
              state_d = S_KEY_RD;
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_KEY_RD: begin
        raddr_o = i_q[AW-1:0];
        state_d = S_KEY_LAT;
      end
      S_KEY_LAT: begin
        key_d   = rdata_i;
        j_d     = i_q;
        raddr_o = i_dec[AW-1:0];
        state_d = S_CMP;
      end
      S_CMP: begin
        // Shift the larger neighbor up, or drop the key into its slot.
        we_o    = 1'b1;
        waddr_o = j_q[AW-1:0];
        if (rdata_i.lo > key_q.lo) begin
          wdata_o = rdata_i;
          j_d     = j_dec;
          raddr_o = j_dec2[AW-1:0];
          if (j_q == CW'(1)) begin
            state_d = S_PLACE;
          end
        end else begin
          wdata_o = key_q;
          i_d     = i_inc;
          raddr_o = i_inc[AW-1:0];
          state_d = (i_inc == cnt_q) ? S_SCAN_RD0 : S_KEY_LAT;
        end
      end
      S_PLACE: begin
        we_o    = 1'b1;
        waddr_o = '0;
        wdata_o = key_q;
        i_d     = i_inc;
        raddr_o = i_inc[AW-1:0];
        state_d = (i_inc == cnt_q) ? S_SCAN_RD0 : S_KEY_LAT;
      end
      S_SCAN_RD0: begin
        raddr_o = '0;
        state_d = S_SCAN_FIRST;
      end
      S_SCAN_FIRST: begin
        edge_d  = rdata_i.hi;
        i_d     = CW'(1);
        raddr_o = AW'(1);
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (rdata_i.lo < edge_q) begin
          if (rem_q != ioc_pkg::COUNT_SAT) begin
            rem_d = rem_q + 1'b1;
          end
          if (rdata_i.hi < edge_q) begin
            edge_d = rdata_i.hi;
          end
        end else begin
          edge_d = rdata_i.hi;
        end
        i_d     = i_inc;
        raddr_o = i_inc[AW-1:0];
        if (i_inc == cnt_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_free_i) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    key_q  <= key_d;
    edge_q <= edge_d;
    rem_q  <= rem_d;
  end

  assign res_o.removal_count = rem_q;
  assign res_o.overflowed    = ovf_q;
  assign count_o             = cnt_q;

endmodule

[sv/interval_overlap_removal_count.sv]
// Loading accepts one interval per cycle; the input is stalled from the last transfer on.
// After the last interval of a set with at least two intervals, an insertion sort by start runs
// in the interval memory, which has one read port and one write port.
// The scan then counts removals, and the result waits until the output register takes it.
// Reset clears the control state and the count; memory contents stay undefined until written.
`include "interval_overlap_removal_count_macros.svh"

module interval_overlap_removal_count #(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ioc_pkg::VALUE_W-1:0]   interval_start_i,
  input  logic signed [ioc_pkg::VALUE_W-1:0]   interval_end_i,
  input  logic                                 last_of_set_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ioc_pkg::COUNT_W-1:0]          removal_count_o,
  output logic                                 overflowed_o
);

  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);

  logic           we;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  ioc_pkg::span_t wdata;
  ioc_pkg::span_t rdata;
  logic           res_valid;
  logic           res_free;
  logic           res_take;
  ioc_pkg::res_t  res;
  logic [CW-1:0]  count;

  logic           out_valid_q, out_valid_d;
  ioc_pkg::res_t  out_q, out_d;

  ioc_store #(
    .DEPTH (MAX_INTERVALS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ioc_seq #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .AW            (AW),
    .CW            (CW)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .interval_start_i (interval_start_i),
    .interval_end_i   (interval_end_i),
    .last_of_set_i    (last_of_set_i),
    .we_o             (we),
    .waddr_o          (waddr),
    .wdata_o          (wdata),
    .raddr_o          (raddr),
    .rdata_i          (rdata),
    .res_free_i       (res_free),
    .res_valid_o      (res_valid),
    .res_o            (res),
    .count_o          (count)
  );

  // The output register takes a new result whenever it is empty or being drained.
  assign res_free = !out_valid_q || !out_stall_i;
  assign res_take = res_valid && res_free;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_take) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign removal_count_o = out_q.removal_count;
  assign overflowed_o    = out_q.overflowed;

  `IOC_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count > CW'(MAX_INTERVALS))
  `IOC_ASSERT(a_set_cleared, clk_i, rst_ni, res_take |=> (count == '0) && !in_stall_o)
  `IOC_ASSERT(a_no_overwrite, clk_i, rst_ni, (out_valid_q && out_stall_i) |=> !$past(res_take))

endmodule
